/* hdl/assert_macros.svh */
// ---------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, clocked on clk, reset by rst_n
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every clock edge outside reset
`define RCP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define RCP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/rcp_pkg.sv */
// ---------------------------------------------------------------------------
// rcp_pkg
// shared types and constants of the ray against convex polygon hit test
// ---------------------------------------------------------------------------
package rcp_pkg;

    localparam int RCP_COORD_BITS = 24;

    typedef enum logic [1:0] {
        CMD_ORIGIN = 2'd0,
        CMD_DIR    = 2'd1,
        CMD_VERTEX = 2'd2,
        CMD_NONE   = 2'd3
    } rcp_cmd_e;

    localparam logic [1:0] CULL_NONE = 2'd0;
    localparam logic [1:0] CULL_CW   = 2'd1;

    // control part of one queued request
    typedef struct packed {
        rcp_cmd_e   kind;
        logic       last;
        logic [1:0] cull;
    } rcp_ctl_t;

endpackage

/* hdl/rcp_front.sv */
// ---------------------------------------------------------------------------
// rcp_front
// accepts requests, drops unused commands, two-entry queue to the back end
// ---------------------------------------------------------------------------
module rcp_front #(
    parameter int COORD_BITS = rcp_pkg::RCP_COORD_BITS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    output logic                         full,
    input  logic [1:0]                   cmd,
    input  logic signed [COORD_BITS-1:0] coord_x,
    input  logic signed [COORD_BITS-1:0] coord_y,
    input  logic signed [COORD_BITS-1:0] coord_z,
    input  logic                         last_vertex,
    input  logic [1:0]                   cull_mode,
    output logic                         q_valid,
    input  logic                         q_ready,
    output rcp_pkg::rcp_ctl_t            q_ctl,
    output logic signed [COORD_BITS-1:0] q_x,
    output logic signed [COORD_BITS-1:0] q_y,
    output logic signed [COORD_BITS-1:0] q_z
);
    import rcp_pkg::*;

    rcp_ctl_t                  ctl_mem [2];
    logic signed [COORD_BITS-1:0] x_mem [2];
    logic signed [COORD_BITS-1:0] y_mem [2];
    logic signed [COORD_BITS-1:0] z_mem [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       wr_en;
    logic       rd_en;

    assign full    = (cnt_reg == 2'd2);
    assign q_valid = (cnt_reg != 2'd0);
    // unused command is taken but never queued
    assign wr_en   = push && !full && (rcp_cmd_e'(cmd) != CMD_NONE);
    assign rd_en   = q_valid && q_ready;
    assign q_ctl   = ctl_mem[rd_ptr_reg];
    assign q_x     = x_mem[rd_ptr_reg];
    assign q_y     = y_mem[rd_ptr_reg];
    assign q_z     = z_mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ctl_mem[wr_ptr_reg] <= '{kind: rcp_cmd_e'(cmd), last: last_vertex, cull: cull_mode};
            x_mem[wr_ptr_reg]   <= coord_x;
            y_mem[wr_ptr_reg]   <= coord_y;
            z_mem[wr_ptr_reg]   <= coord_z;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (wr_en)
                wr_ptr_reg <= !wr_ptr_reg;
            if (rd_en)
                rd_ptr_reg <= !rd_ptr_reg;
            if (wr_en && !rd_en)
                cnt_reg <= cnt_reg + 2'd1;
            else if (!wr_en && rd_en)
                cnt_reg <= cnt_reg - 2'd1;
        end
    end

endmodule

/* hdl/rcp_back.sv */
// ---------------------------------------------------------------------------
// rcp_back
// sequencer over one shared signed multiplier: edge signs, normal, normal tests
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module rcp_back #(
    parameter int COORD_BITS = rcp_pkg::RCP_COORD_BITS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  rcp_pkg::rcp_ctl_t            in_ctl,
    input  logic signed [COORD_BITS-1:0] in_x,
    input  logic signed [COORD_BITS-1:0] in_y,
    input  logic signed [COORD_BITS-1:0] in_z,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         out_hit
);
    import rcp_pkg::*;

    localparam int W     = COORD_BITS;
    localparam int DW    = W + 1;
    localparam int AW    = W + 2;
    localparam int PW    = AW + DW;
    localparam int CW    = 2 * W + 2;
    localparam int K     = W + 1;
    localparam int ACC_W = 3 * W + 5;

    localparam logic [3:0] STEP_CROSS_END = 4'd5;
    localparam logic [3:0] STEP_DOT_START = 4'd6;
    localparam logic [3:0] STEP_LAST      = 4'd11;

    typedef enum logic [2:0] {
        P_IDLE, P_EDGE, P_NORM, P_DOTA, P_DOTB, P_EMIT
    } phase_t;

    phase_t            phase_reg;
    logic [3:0]        step_reg;
    logic signed [W-1:0]  org_reg  [3];
    logic signed [W-1:0]  dir_reg  [3];
    logic signed [W-1:0]  v0_reg   [3];
    logic signed [W-1:0]  v1_reg   [3];
    logic signed [W-1:0]  prev_reg [3];
    logic signed [W-1:0]  cur_reg  [3];
    logic signed [CW-1:0] c_reg    [3];
    logic signed [ACC_W-1:0] acc_reg;
    logic [1:0]        count_reg;
    logic              fes_reg;
    logic              mis_reg;
    logic              last_reg;
    logic [1:0]        cull_reg;
    logic              sel_reg;
    logic              sa_neg_reg;
    logic              sa_zero_reg;
    logic              hit_reg;

    logic signed [DW-1:0] e_v [3];
    logic signed [DW-1:0] a_v [3];
    logic signed [DW-1:0] p_v [3];
    logic signed [DW-1:0] q_v [3];
    logic signed [DW-1:0] f_v [3];
    logic signed [DW-1:0] d_v [3];
    logic signed [DW-1:0] x_v [3];
    logic signed [DW-1:0] y_v [3];
    logic signed [DW-1:0] dot_v [3];
    logic signed [W-1:0]  from_v [3];
    logic signed [W-1:0]  to_v [3];
    logic signed [W-1:0]  in_v [3];

    logic              is_cross;
    logic              odd;
    logic [1:0]        ci;
    logic [1:0]        j1;
    logic [1:0]        j2;
    logic [1:0]        di;
    logic signed [AW-1:0]    op_a;
    logic signed [DW-1:0]    op_b;
    logic signed [PW-1:0]    prod;
    logic signed [ACC_W-1:0] prod_ext;
    logic signed [ACC_W-1:0] acc_base;
    logic signed [ACC_W-1:0] acc_next;
    logic              res_neg;
    logic              res_zero;
    logic              res_pos;
    logic [1:0]        count_inc;
    logic              n_nonzero;
    logic              sa_pos;
    logic              sb_pos;
    logic              hit_calc;

    assign in_v[0] = in_x;
    assign in_v[1] = in_y;
    assign in_v[2] = in_z;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            from_v[i] = sel_reg ? cur_reg[i] : prev_reg[i];
            to_v[i]   = sel_reg ? v0_reg[i]  : cur_reg[i];
            e_v[i] = DW'(from_v[i]) - DW'(org_reg[i]);
            a_v[i] = DW'(to_v[i]) - DW'(from_v[i]);
            p_v[i] = DW'(v1_reg[i]) - DW'(v0_reg[i]);
            q_v[i] = DW'(cur_reg[i]) - DW'(v0_reg[i]);
            f_v[i] = DW'(v0_reg[i]) - DW'(org_reg[i]);
            d_v[i] = DW'(dir_reg[i]);
            x_v[i] = (phase_reg == P_EDGE) ? d_v[i] : p_v[i];
            y_v[i] = (phase_reg == P_EDGE) ? e_v[i] : q_v[i];
            case (phase_reg)
                P_DOTA:  dot_v[i] = f_v[i];
                P_DOTB:  dot_v[i] = d_v[i];
                default: dot_v[i] = a_v[i];
            endcase
        end
    end

    // step decode: cross products on steps 0 to 5, dot products on 6 to 11
    assign is_cross = (step_reg <= STEP_CROSS_END);
    assign odd      = step_reg[0];
    assign ci       = step_reg[2:1];

    always_comb
    begin
        case (ci)
            2'd0:    begin j1 = 2'd1; j2 = 2'd2; end
            2'd1:    begin j1 = 2'd2; j2 = 2'd0; end
            default: begin j1 = 2'd0; j2 = 2'd1; end
        endcase
        case (step_reg)
            4'd6, 4'd7: di = 2'd0;
            4'd8, 4'd9: di = 2'd1;
            default:    di = 2'd2;
        endcase
    end

    // operands: cross term pairs, or low and high halves of a stored component
    always_comb
    begin
        if (is_cross)
        begin
            op_a = odd ? AW'(x_v[j2]) : AW'(x_v[j1]);
            op_b = odd ? y_v[j1] : y_v[j2];
        end
        else
        begin
            op_a = odd ? $signed({c_reg[di][CW-1], c_reg[di][CW-1:K]})
                       : $signed({1'b0, c_reg[di][K-1:0]});
            op_b = dot_v[di];
        end
    end

    assign prod     = PW'(op_a) * PW'(op_b);
    assign prod_ext = (!is_cross && odd) ? (ACC_W'(prod) <<< K) : ACC_W'(prod);
    assign acc_base = ((is_cross && !odd) || (step_reg == STEP_DOT_START)) ? '0 : acc_reg;
    assign acc_next = (is_cross && odd) ? (acc_base - prod_ext) : (acc_base + prod_ext);
    assign res_neg  = acc_next[ACC_W-1];
    assign res_zero = (acc_next == '0);
    assign res_pos  = !res_neg && !res_zero;

    assign count_inc = (count_reg == 2'd3) ? 2'd3 : (count_reg + 2'd1);
    assign n_nonzero = (c_reg[0] != '0) || (c_reg[1] != '0) || (c_reg[2] != '0);
    assign sa_pos    = !sa_neg_reg && !sa_zero_reg;
    assign sb_pos    = res_pos;

    always_comb
    begin
        hit_calc = !mis_reg;
        if (n_nonzero)
        begin
            if ((sa_neg_reg && sb_pos) || (sa_pos && res_neg))
                hit_calc = 1'b0;
            if (cull_reg == CULL_CW)
            begin
                if (!sb_pos)
                    hit_calc = 1'b0;
            end
            else if (cull_reg != CULL_NONE)
            begin
                if (!res_neg)
                    hit_calc = 1'b0;
            end
        end
    end

    assign in_ready  = (phase_reg == P_IDLE);
    assign out_valid = (phase_reg == P_EMIT);
    assign out_hit   = hit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= P_IDLE;
            step_reg    <= 4'd0;
            for (int i = 0; i < 3; i++)
            begin
                org_reg[i]  <= '0;
                dir_reg[i]  <= '0;
                v0_reg[i]   <= '0;
                v1_reg[i]   <= '0;
                prev_reg[i] <= '0;
                cur_reg[i]  <= '0;
                c_reg[i]    <= '0;
            end
            acc_reg     <= '0;
            count_reg   <= 2'd0;
            fes_reg     <= 1'b0;
            mis_reg     <= 1'b0;
            last_reg    <= 1'b0;
            cull_reg    <= CULL_NONE;
            sel_reg     <= 1'b0;
            sa_neg_reg  <= 1'b0;
            sa_zero_reg <= 1'b0;
            hit_reg     <= 1'b0;
        end
        else
        begin
            case (phase_reg)
                P_IDLE:
                begin
                    if (in_valid)
                    begin
                        case (in_ctl.kind)
                            CMD_ORIGIN: org_reg <= in_v;
                            CMD_DIR:    dir_reg <= in_v;
                            CMD_VERTEX:
                            begin
                                cur_reg  <= in_v;
                                last_reg <= in_ctl.last;
                                cull_reg <= in_ctl.cull;
                                if (count_reg == 2'd0)
                                begin
                                    v0_reg    <= in_v;
                                    prev_reg  <= in_v;
                                    count_reg <= 2'd1;
                                    if (in_ctl.last)
                                    begin
                                        hit_reg   <= 1'b0;
                                        phase_reg <= P_EMIT;
                                    end
                                end
                                else
                                begin
                                    sel_reg   <= 1'b0;
                                    step_reg  <= 4'd0;
                                    phase_reg <= P_EDGE;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                P_EDGE:
                begin
                    acc_reg  <= acc_next;
                    step_reg <= step_reg + 4'd1;
                    if (is_cross && odd)
                        c_reg[ci] <= acc_next[CW-1:0];
                    if (step_reg == STEP_LAST)
                    begin
                        step_reg <= 4'd0;
                        if (!sel_reg)
                        begin
                            if (count_reg == 2'd1)
                            begin
                                fes_reg <= res_pos;
                                v1_reg  <= cur_reg;
                            end
                            else if (res_pos != fes_reg)
                                mis_reg <= 1'b1;
                            prev_reg  <= cur_reg;
                            count_reg <= count_inc;
                            if (!last_reg)
                                phase_reg <= P_IDLE;
                            else if (count_inc != 2'd3)
                            begin
                                hit_reg   <= 1'b0;
                                phase_reg <= P_EMIT;
                            end
                            else
                                sel_reg <= 1'b1;
                        end
                        else
                        begin
                            // closing edge from the last vertex back to the first
                            if (res_pos != fes_reg)
                                mis_reg <= 1'b1;
                            phase_reg <= P_NORM;
                        end
                    end
                end
                P_NORM:
                begin
                    acc_reg  <= acc_next;
                    step_reg <= step_reg + 4'd1;
                    if (odd)
                        c_reg[ci] <= acc_next[CW-1:0];
                    if (step_reg == STEP_CROSS_END)
                        phase_reg <= P_DOTA;
                end
                P_DOTA:
                begin
                    acc_reg  <= acc_next;
                    step_reg <= step_reg + 4'd1;
                    if (step_reg == STEP_LAST)
                    begin
                        sa_neg_reg  <= res_neg;
                        sa_zero_reg <= res_zero;
                        step_reg    <= STEP_DOT_START;
                        phase_reg   <= P_DOTB;
                    end
                end
                P_DOTB:
                begin
                    acc_reg  <= acc_next;
                    step_reg <= step_reg + 4'd1;
                    if (step_reg == STEP_LAST)
                    begin
                        hit_reg   <= hit_calc;
                        step_reg  <= 4'd0;
                        phase_reg <= P_EMIT;
                    end
                end
                P_EMIT:
                begin
                    if (out_ready)
                    begin
                        count_reg <= 2'd0;
                        fes_reg   <= 1'b0;
                        mis_reg   <= 1'b0;
                        phase_reg <= P_IDLE;
                    end
                end
                default: phase_reg <= P_IDLE;
            endcase
        end
    end

    `RCP_ASSERT(a_step_range, step_reg <= STEP_LAST, "step counter out of range")
    `RCP_ASSERT(a_ready_idle, !in_ready || !out_valid, "request taken while result pending")
    `RCP_ASSERT_NEXT(a_emit_clears, out_valid && out_ready, count_reg == 2'd0 && !mis_reg,
        "polygon state not cleared after result")
    `RCP_ASSERT_NEXT(a_norm_to_dot, phase_reg == P_NORM && step_reg == STEP_CROSS_END,
        phase_reg == P_DOTA && step_reg == STEP_DOT_START, "normal not followed by dot")

endmodule

/* hdl/ray_convex_polygon_hit_test.sv */
// ---------------------------------------------------------------------------
// ray_convex_polygon_hit_test
// exact fixed point hit test of a ray against a streamed convex polygon
// ---------------------------------------------------------------------------
// requests set the ray origin, the ray direction, or carry one polygon vertex;
// the request flagged as last vertex yields one hit bit on the result side.
// a front queue of two requests takes requests while the back end works, and
// a one-entry result register lets the back end finish while a result waits.
// all arithmetic goes through one shared signed multiplier, one product per
// cycle: origin and direction requests and the first vertex of a polygon are
// only stored; any later vertex is taken and then needs twelve products for
// the edge sign; a last vertex of a polygon of three or more vertices then
// adds the closing edge, the normal, two dot products of six products each
// and the result hand-over.
// unused command codes are taken and dropped; fewer than three vertices give
// no hit; a zero normal leaves only the edge signs to decide.
module ray_convex_polygon_hit_test #(
    parameter int COORD_BITS = rcp_pkg::RCP_COORD_BITS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // request side
    input  logic                         push,
    output logic                         full,
    input  logic [1:0]                   cmd,
    input  logic signed [COORD_BITS-1:0] coord_x,
    input  logic signed [COORD_BITS-1:0] coord_y,
    input  logic signed [COORD_BITS-1:0] coord_z,
    input  logic                         last_vertex,
    input  logic [1:0]                   cull_mode,
    // result side
    output logic                         empty,
    input  logic                         pop,
    output logic                         hit
);
    import rcp_pkg::*;

    rcp_ctl_t                     q_ctl;
    logic                         q_valid;
    logic                         q_ready;
    logic signed [COORD_BITS-1:0] q_x;
    logic signed [COORD_BITS-1:0] q_y;
    logic signed [COORD_BITS-1:0] q_z;
    logic                         b_valid;
    logic                         b_ready;
    logic                         b_hit;
    logic                         res_valid_reg;
    logic                         res_hit_reg;

    // front: accept and classify
    rcp_front #(.COORD_BITS(COORD_BITS)) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .cmd         (cmd),
        .coord_x     (coord_x),
        .coord_y     (coord_y),
        .coord_z     (coord_z),
        .last_vertex (last_vertex),
        .cull_mode   (cull_mode),
        .q_valid     (q_valid),
        .q_ready     (q_ready),
        .q_ctl       (q_ctl),
        .q_x         (q_x),
        .q_y         (q_y),
        .q_z         (q_z)
    );

    // back: arithmetic sequencer
    rcp_back #(.COORD_BITS(COORD_BITS)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (q_valid),
        .in_ready  (q_ready),
        .in_ctl    (q_ctl),
        .in_x      (q_x),
        .in_y      (q_y),
        .in_z      (q_z),
        .out_valid (b_valid),
        .out_ready (b_ready),
        .out_hit   (b_hit)
    );

    // result register, refilled in the cycle it is popped
    assign b_ready = !res_valid_reg || pop;
    assign empty   = !res_valid_reg;
    assign hit     = res_hit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (b_ready)
            res_valid_reg <= b_valid;
    end

    always_ff @(posedge clk)
    begin
        if (b_ready && b_valid)
            res_hit_reg <= b_hit;
    end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// self-checking bench for the ray against convex polygon hit test
// ---------------------------------------------------------------------------
// ray and vertex requests go in through the push side and hit bits come back
// through the pop side. a predictor inside a scoreboard class works out each
// expected hit bit with exact wide integer arithmetic. every popped result is
// checked against the oldest expected one.
// ---------------------------------------------------------------------------
module tb_top;
    import rcp_pkg::*;

    localparam int CB = RCP_COORD_BITS;
    localparam int WB = 4 * CB + 8;            // wide enough for any product sum
    localparam int WDOG_LIMIT = 4000;
    localparam int N_RANDOM_POLY = 116;

    typedef logic signed [CB-1:0] coord_t;
    typedef logic signed [WB-1:0] wide_t;
    typedef wide_t wvec_t [3];

    int n_errors = 0;

    // one line per mismatch, counted
    task automatic report_mismatch(input string what);
        n_errors++;
        $display("mismatch at %0t: %s", $realtime, what);
    endtask

    // -----------------------------------------------------------------------
    // hit predictor and queue of expected hit bits
    // -----------------------------------------------------------------------
    class hit_scoreboard;
        coord_t ray_org [3];
        coord_t ray_dir [3];
        coord_t v_first [3];
        coord_t v_second [3];
        coord_t v_prev [3];
        int     n_vert;
        bit     first_sign;
        bit     sign_bad;
        bit     expected_hits [$];

        function new();
            for (int i = 0; i < 3; i++)
            begin
                ray_org[i] = '0;
                ray_dir[i] = '0;
                v_first[i] = '0;
                v_second[i] = '0;
                v_prev[i] = '0;
            end
            n_vert = 0;
            first_sign = 0;
            sign_bad = 0;
        endfunction

        function automatic wvec_t diff(input coord_t a [3], input coord_t b [3]);
            wvec_t r;
            for (int i = 0; i < 3; i++)
                r[i] = wide_t'(a[i]) - wide_t'(b[i]);
            return r;
        endfunction

        function automatic wvec_t cross3(input wvec_t a, input wvec_t b);
            wvec_t r;
            r[0] = a[1] * b[2] - a[2] * b[1];
            r[1] = a[2] * b[0] - a[0] * b[2];
            r[2] = a[0] * b[1] - a[1] * b[0];
            return r;
        endfunction

        function automatic wide_t dot3(input wvec_t a, input wvec_t b);
            return a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
        endfunction

        function automatic int sgn(input wide_t v);
            return (v < 0) ? -1 : ((v > 0) ? 1 : 0);
        endfunction

        // true when the edge from -> to turns positively around the ray
        function automatic bit edge_pos(input coord_t from [3], input coord_t to [3]);
            wvec_t d;
            for (int i = 0; i < 3; i++)
                d[i] = wide_t'(ray_dir[i]);
            return dot3(cross3(d, diff(from, ray_org)), diff(to, from)) > 0;
        endfunction

        // note an accepted request, queueing a hit bit where one is due
        function void note_request(input logic [1:0] c, input coord_t p [3],
                                   input bit last, input logic [1:0] cull);
            bit h;
            wvec_t n, d;
            int sa, sb;
            if (c == CMD_ORIGIN)
            begin
                ray_org = p;
                return;
            end
            if (c == CMD_DIR)
            begin
                ray_dir = p;
                return;
            end
            if (c != CMD_VERTEX)
                return;
            if (n_vert == 0)
                v_first = p;
            else if (n_vert == 1)
            begin
                first_sign = edge_pos(v_prev, p);
                v_second = p;
            end
            else if (edge_pos(v_prev, p) != first_sign)
                sign_bad = 1;
            v_prev = p;
            if (n_vert < 3)
                n_vert++;
            if (!last)
                return;
            if (n_vert < 3)
                h = 0;
            else
            begin
                if (edge_pos(p, v_first) != first_sign)
                    sign_bad = 1;
                h = !sign_bad;
                n = cross3(diff(v_second, v_first), diff(p, v_first));
                if (cull == CULL_CW)
                    for (int i = 0; i < 3; i++)
                        n[i] = -n[i];
                if (n[0] != 0 || n[1] != 0 || n[2] != 0)
                begin
                    for (int i = 0; i < 3; i++)
                        d[i] = wide_t'(ray_dir[i]);
                    sa = sgn(dot3(diff(v_first, ray_org), n));
                    sb = sgn(dot3(d, n));
                    if (sa * sb < 0)
                        h = 0;
                    if (cull != CULL_NONE && sb >= 0)
                        h = 0;
                end
            end
            n_vert = 0;
            first_sign = 0;
            sign_bad = 0;
            expected_hits.push_back(h);
        endfunction

        // compare one popped hit bit with the oldest expectation
        task automatic check_hit(input logic h);
            bit want;
            if (expected_hits.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result hit=%b", h));
                return;
            end
            want = expected_hits.pop_front();
            if (h !== want)
                report_mismatch($sformatf("hit=%b, expected %b", h, want));
        endtask
    endclass

    // -----------------------------------------------------------------------
    // clock, reset, block
    // -----------------------------------------------------------------------
    logic clk = 0;
    logic rst_n = 0;
    logic push = 0;
    logic [1:0] cmd = '0;
    coord_t coord_x = '0, coord_y = '0, coord_z = '0;
    logic last_vertex = 0;
    logic [1:0] cull_mode = '0;
    logic pop = 0;
    logic full, empty, hit;

    initial
    begin
        forever #1 clk = ~clk;
    end

    ray_convex_polygon_hit_test dut (
        .clk(clk), .rst_n(rst_n),
        .push(push), .full(full), .cmd(cmd),
        .coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z),
        .last_vertex(last_vertex), .cull_mode(cull_mode),
        .empty(empty), .pop(pop), .hit(hit)
    );

    hit_scoreboard sb = new();

    // idle percentages of sender and receiver, changed per phase
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int quiet_cycles = 0;

    // receiver: pop decided at the falling edge, result taken at the rising edge
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            pop <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
            sb.check_hit(hit);
    end

    // watchdog on cycles without any accepted request or result
    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WDOG_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // -----------------------------------------------------------------------
    // request drivers
    // -----------------------------------------------------------------------
    // drive one request and hold it until taken; push stays high so that the
    // next request can follow straight on, idling or a pause drops it
    task automatic send_request(input logic [1:0] c, input coord_t x, input coord_t y,
                                input coord_t z, input bit last, input logic [1:0] cull);
        coord_t p [3];
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 0;
            @(negedge clk);
        end
        push <= 1;
        cmd <= c;
        coord_x <= x;
        coord_y <= y;
        coord_z <= z;
        last_vertex <= last;
        cull_mode <= cull;
        @(posedge clk);
        while (full)
            @(posedge clk);
        p[0] = x;
        p[1] = y;
        p[2] = z;
        sb.note_request(c, p, last, cull);
        @(negedge clk);
    endtask

    function automatic coord_t rand_full();
        return coord_t'($urandom);
    endfunction

    // mostly moderate values, sometimes the extremes of the field
    function automatic coord_t rand_coord();
        case ($urandom_range(9))
            0: return rand_full();
            1: return {1'b0, {(CB-1){1'b1}}};
            2: return {1'b1, {(CB-1){1'b0}}};
            default: return coord_t'($signed($urandom_range(4096)) - 2048);
        endcase
    endfunction

    // ray at origin area shooting along z through a polygon near z = 0
    task automatic send_ray();
        send_request(CMD_ORIGIN, rand_coord() >>> 4, rand_coord() >>> 4,
                     coord_t'(-($urandom_range(4000) + 1)), 0, 2'($urandom));
        send_request(CMD_DIR, coord_t'($signed($urandom_range(40)) - 20),
                     coord_t'($signed($urandom_range(40)) - 20),
                     ($urandom_range(3) == 0) ? coord_t'(-$urandom_range(300))
                                              : coord_t'($urandom_range(300)),
                     $urandom_range(1), '0);
    endtask

    // convex polygon on a circle, either winding, a few corners
    task automatic send_polygon(input int corners, input logic [1:0] cull);
        int r;
        bit cw;
        real a;
        r = $urandom_range(2000) + 50;
        cw = $urandom_range(1);
        for (int k = 0; k < corners; k++)
        begin
            a = 6.2831853 * k / corners * (cw ? -1.0 : 1.0);
            send_request(CMD_VERTEX, coord_t'($rtoi(r * $cos(a))),
                         coord_t'($rtoi(r * $sin(a))),
                         coord_t'($signed($urandom_range(8)) - 4),
                         k == corners - 1, cull);
        end
    endtask

    task automatic wait_drained();
        push <= 0;
        while (sb.expected_hits.size() != 0)
            @(negedge clk);
        repeat (80) @(negedge clk);
    endtask

    // -----------------------------------------------------------------------
    // test sequence
    // -----------------------------------------------------------------------
    initial
    begin
        repeat (8) @(negedge clk);
        rst_n <= 1;
        @(negedge clk);

        // directed part
        send_request(CMD_VERTEX, 0, 0, 0, 1, CULL_NONE);          // short polygon
        send_request(CMD_ORIGIN, 0, 0, -256, 1, 2'd0);              // last bit ignored
        send_request(CMD_DIR, 0, 0, 256, 1, 2'd0);
        send_request(CMD_NONE, rand_full(), rand_full(), rand_full(), 1, 2'd3);
        send_request(CMD_VERTEX, -512, -512, 0, 0, 2'd0);
        send_request(CMD_VERTEX, 512, -512, 0, 0, 2'd0);
        send_request(CMD_VERTEX, 0, 512, 0, 1, 2'd2);               // ccw, front
        send_request(CMD_VERTEX, -512, -512, 0, 0, 2'd0);
        send_request(CMD_VERTEX, 0, 512, 0, 0, 2'd0);
        send_request(CMD_DIR, 0, 0, -256, 0, 2'd0);                 // ray changed mid way
        send_request(CMD_VERTEX, 512, -512, 0, 1, 2'd1);            // cw cull
        send_request(CMD_VERTEX, 0, 0, 0, 0, 2'd0);                 // zero normal
        send_request(CMD_VERTEX, 0, 0, 0, 0, 2'd0);
        send_request(CMD_VERTEX, 0, 0, 0, 1, 2'd3);
        send_request(CMD_ORIGIN, {1'b1, {(CB-1){1'b0}}}, {1'b0, {(CB-1){1'b1}}},
                     {1'b1, {(CB-1){1'b0}}}, 0, 2'd0);
        send_request(CMD_DIR, {1'b0, {(CB-1){1'b1}}}, {1'b1, {(CB-1){1'b0}}},
                     {1'b0, {(CB-1){1'b1}}}, 0, 2'd0);
        send_request(CMD_VERTEX, {1'b0, {(CB-1){1'b1}}}, {1'b1, {(CB-1){1'b0}}}, 0, 0, 0);
        send_request(CMD_VERTEX, {1'b1, {(CB-1){1'b0}}}, {1'b0, {(CB-1){1'b1}}},
                     {1'b0, {(CB-1){1'b1}}}, 0, 0);
        send_request(CMD_VERTEX, -1, -1, {1'b1, {(CB-1){1'b0}}}, 1, 2'd1);
        send_request(CMD_VERTEX, 5, 5, 5, 0, 0);
        send_request(CMD_VERTEX, 7, 9, 1, 1, 2'd0);                 // two vertices
        // pause until every expected result has come
        wait_drained();

        // random phases with different idling
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
                default: begin send_idle_pct = 23; recv_stall_pct = 23; end
            endcase
            for (int k = 0; k < N_RANDOM_POLY / 4; k++)
            begin
                case ($urandom_range(9))
                    0: send_request(2'($urandom), rand_full(), rand_full(), rand_full(),
                                    $urandom_range(1), 2'($urandom));
                    1: send_polygon($urandom_range(1, 2), 2'($urandom));
                    2: begin
                        send_ray();
                        send_request(CMD_VERTEX, rand_coord(), rand_coord(),
                                     rand_coord(), 0, 0);
                        send_request(CMD_VERTEX, rand_coord(), rand_coord(),
                                     rand_coord(), 0, 0);
                        send_request(CMD_VERTEX, rand_coord(), rand_coord(),
                                     rand_coord(), 1, 2'($urandom));
                    end
                    default: begin
                        if ($urandom_range(1))
                            send_ray();
                        send_polygon($urandom_range(3, 6), 2'($urandom));
                    end
                endcase
            end
            if (ph == 1)
                wait_drained();
        end

        // drain, then settle
        push <= 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        while (sb.expected_hits.size() != 0)
            @(negedge clk);
        repeat (100) @(negedge clk);
        if (n_errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

/* sim.f */
+incdir+hdl
hdl/rcp_pkg.sv
hdl/rcp_front.sv
hdl/rcp_back.sv
hdl/ray_convex_polygon_hit_test.sv
tb/tb_top.sv
